/* hw/rtl/linked_block_allocator_defines.svh */
// ----------------------------------------------------------------------------
// linked block allocator assertion macros
// concurrent check helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef LINKED_BLOCK_ALLOCATOR_DEFINES_SVH
`define LINKED_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/lba_pkg.sv */
// ----------------------------------------------------------------------------
// lba_pkg
// shared types and codes of the linked block allocator
// ----------------------------------------------------------------------------
package lba_pkg;

	localparam int STEP_W = 4;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_TOO_BIG   = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_NO_ROOM   = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	// datapath operations, one per microcode step
	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LATCH,
		OP_FT_SCAN,
		OP_REJECT,
		OP_ALLOC_INIT,
		OP_ALLOC_SCAN,
		OP_ALLOC_TAIL,
		OP_DEL_INIT,
		OP_DEL_WALK,
		OP_DEL_TAIL,
		OP_REPLY
	} op_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NOT_START,
		C_NOT_CLR_LAST,
		C_NOT_FT_LAST,
		C_KIND,
		C_INS_REJECT,
		C_NOT_FOUND,
		C_NOT_ALLOC_END,
		C_MORE_LINKS
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              idle;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic idle;
	} ctl_t;

	typedef struct packed {
		logic chk_last;
		logic ft_last;
		logic kind;
		logic ins_reject;
		logic not_found;
		logic alloc_end;
		logic more_links;
	} flags_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] start_block;
		logic [5:0] free_count;
	} result_t;

endpackage

/* hw/rtl/lba_sequencer.sv */
// ----------------------------------------------------------------------------
// lba_sequencer
// step counter and microcode rom with conditional jumps
// ----------------------------------------------------------------------------
module lba_sequencer
	import lba_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  flags_t flags,
	output ctl_t   ctl
);

	localparam logic [STEP_W-1:0] S_CLEAR      = 4'd0;
	localparam logic [STEP_W-1:0] S_IDLE       = 4'd1;
	localparam logic [STEP_W-1:0] S_FT_SCAN    = 4'd2;
	localparam logic [STEP_W-1:0] S_DISPATCH   = 4'd3;
	localparam logic [STEP_W-1:0] S_INS_CHK    = 4'd4;
	localparam logic [STEP_W-1:0] S_ALLOC_INIT = 4'd5;
	localparam logic [STEP_W-1:0] S_ALLOC_SCAN = 4'd6;
	localparam logic [STEP_W-1:0] S_ALLOC_TAIL = 4'd7;
	localparam logic [STEP_W-1:0] S_DEL_CHK    = 4'd8;
	localparam logic [STEP_W-1:0] S_DEL_INIT   = 4'd9;
	localparam logic [STEP_W-1:0] S_DEL_WALK   = 4'd10;
	localparam logic [STEP_W-1:0] S_DEL_TAIL   = 4'd11;
	localparam logic [STEP_W-1:0] S_REPLY      = 4'd12;

	function automatic uword_t ucode(input logic [STEP_W-1:0] a);
		uword_t w;
		unique case (a)
			S_CLEAR:      w = '{OP_CLEAR,      C_NOT_CLR_LAST,  S_CLEAR,      1'b0};
			S_IDLE:       w = '{OP_LATCH,      C_NOT_START,     S_IDLE,       1'b1};
			S_FT_SCAN:    w = '{OP_FT_SCAN,    C_NOT_FT_LAST,   S_FT_SCAN,    1'b0};
			S_DISPATCH:   w = '{OP_NOP,        C_KIND,          S_DEL_CHK,    1'b0};
			S_INS_CHK:    w = '{OP_REJECT,     C_INS_REJECT,    S_REPLY,      1'b0};
			S_ALLOC_INIT: w = '{OP_ALLOC_INIT, C_NEXT,          S_ALLOC_SCAN, 1'b0};
			S_ALLOC_SCAN: w = '{OP_ALLOC_SCAN, C_NOT_ALLOC_END, S_ALLOC_SCAN, 1'b0};
			S_ALLOC_TAIL: w = '{OP_ALLOC_TAIL, C_ALWAYS,        S_REPLY,      1'b0};
			S_DEL_CHK:    w = '{OP_REJECT,     C_NOT_FOUND,     S_REPLY,      1'b0};
			S_DEL_INIT:   w = '{OP_DEL_INIT,   C_NEXT,          S_DEL_WALK,   1'b0};
			S_DEL_WALK:   w = '{OP_DEL_WALK,   C_MORE_LINKS,    S_DEL_WALK,   1'b0};
			S_DEL_TAIL:   w = '{OP_DEL_TAIL,   C_NEXT,          S_REPLY,      1'b0};
			S_REPLY:      w = '{OP_REPLY,      C_ALWAYS,        S_IDLE,       1'b0};
			default:      w = '{OP_NOP,        C_ALWAYS,        S_IDLE,       1'b0};
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] pc_q;
	uword_t            uw;
	logic              jump;

	assign uw = ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			C_NEXT:          jump = 1'b0;
			C_ALWAYS:        jump = 1'b1;
			C_NOT_START:     jump = !start;
			C_NOT_CLR_LAST:  jump = !flags.chk_last;
			C_NOT_FT_LAST:   jump = !flags.ft_last;
			C_KIND:          jump = flags.kind;
			C_INS_REJECT:    jump = flags.ins_reject;
			C_NOT_FOUND:     jump = flags.not_found;
			C_NOT_ALLOC_END: jump = !flags.alloc_end;
			C_MORE_LINKS:    jump = flags.more_links;
			default:         jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_CLEAR;
		end else if (jump) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + STEP_W'(1);
		end
	end

	assign ctl.op   = uw.op;
	assign ctl.idle = uw.idle;

endmodule

/* hw/rtl/lba_datapath.sv */
// ----------------------------------------------------------------------------
// lba_datapath
// block memory, file table, counters and result registers
// ----------------------------------------------------------------------------
module lba_datapath
	import lba_pkg::*;
#(
	parameter int NUM_BLOCKS = 32,
	parameter int NUM_FILES  = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        op,
	input  logic       kind,
	input  logic [7:0] file_key,
	input  logic [5:0] block_count,
	output flags_t     flags,
	output result_t    result
);

	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int FW  = $clog2(NUM_BLOCKS + 1);
	localparam int FIW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
	localparam int CW  = (FW > 6) ? FW : 6;
	localparam int SW  = (BW > 5) ? BW : 5;

	typedef struct packed {
		logic          used;
		logic          more;
		logic [BW-1:0] link;
	} blk_t;

	// block memory
	blk_t          mem [NUM_BLOCKS];
	blk_t          rdata_q;
	logic [BW-1:0] raddr;
	logic [BW-1:0] waddr;
	blk_t          wdata;
	logic          we;

	// file table
	logic [NUM_FILES-1:0] ft_valid_q;
	logic [7:0]           ft_key_q   [NUM_FILES];
	logic [BW-1:0]        ft_start_q [NUM_FILES];

	logic           kind_q;
	logic [7:0]     key_q;
	logic [5:0]     count_q;
	logic [FIW-1:0] fidx_q;
	logic           found_q;
	logic [FIW-1:0] pos_q;
	logic [BW-1:0]  fstart_q;
	logic           slot_ok_q;
	logic [FIW-1:0] slot_q;
	logic [BW-1:0]  chk_q;
	logic [FW-1:0]  taken_q;
	logic           have_prev_q;
	logic [BW-1:0]  prev_q;
	logic [BW-1:0]  first_q;
	logic [BW-1:0]  steps_q;
	logic [BW-1:0]  cur_q;
	logic [FW-1:0]  free_q;
	logic [2:0]     status_q;
	logic [4:0]     start_q;

	logic          chk_last;
	logic          ft_last;
	logic          ft_hit;
	logic          too_big;
	logic          take;
	logic          alloc_end;
	logic          more_links;
	logic [SW-1:0] first_ext;
	logic [SW-1:0] fstart_ext;
	logic [CW-1:0] free_ext;

	assign chk_last   = (chk_q == BW'(NUM_BLOCKS - 1));
	assign ft_last    = (fidx_q == FIW'(NUM_FILES - 1));
	assign ft_hit     = ft_valid_q[fidx_q] && (ft_key_q[fidx_q] == key_q);
	assign too_big    = CW'(count_q) > CW'(free_q);
	assign take       = !rdata_q.used && (CW'(taken_q) < CW'(count_q));
	assign alloc_end  = chk_last || (take && (CW'(taken_q) + CW'(1) == CW'(count_q)));
	assign more_links = rdata_q.more && (steps_q != BW'(NUM_BLOCKS - 1));
	assign first_ext  = SW'(first_q);
	assign fstart_ext = SW'(fstart_q);
	assign free_ext   = CW'(free_q);

	assign flags.chk_last   = chk_last;
	assign flags.ft_last    = ft_last;
	assign flags.kind       = kind_q;
	assign flags.ins_reject = too_big || found_q || (count_q == 6'd0) || !slot_ok_q;
	assign flags.not_found  = !found_q;
	assign flags.alloc_end  = alloc_end;
	assign flags.more_links = more_links;

	assign result.status      = status_q;
	assign result.start_block = start_q;
	assign result.free_count  = free_ext[5:0];

	// memory port selection
	always_comb begin
		raddr = '0;
		waddr = '0;
		wdata = '0;
		we    = 1'b0;
		unique case (op)
			OP_CLEAR: begin
				waddr = chk_q;
				we    = 1'b1;
			end
			OP_ALLOC_INIT: begin
				raddr = '0;
			end
			OP_ALLOC_SCAN: begin
				raddr = chk_last ? chk_q : chk_q + BW'(1);
				// link the previous block to this one
				waddr = prev_q;
				wdata = '{used: 1'b1, more: 1'b1, link: chk_q};
				we    = take && have_prev_q;
			end
			OP_ALLOC_TAIL: begin
				waddr = prev_q;
				wdata = '{used: 1'b1, more: 1'b0, link: '0};
				we    = 1'b1;
			end
			OP_DEL_INIT: begin
				raddr = fstart_q;
			end
			OP_DEL_WALK: begin
				raddr = rdata_q.link;
				waddr = cur_q;
				we    = 1'b1;
			end
			OP_NOP, OP_LATCH, OP_FT_SCAN, OP_REJECT, OP_DEL_TAIL, OP_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q       <= '0;
			free_q      <= FW'(NUM_BLOCKS);
			ft_valid_q  <= '0;
			fidx_q      <= '0;
			found_q     <= 1'b0;
			slot_ok_q   <= 1'b0;
			taken_q     <= '0;
			have_prev_q <= 1'b0;
			steps_q     <= '0;
		end else begin
			unique case (op)
				OP_CLEAR: begin
					chk_q <= chk_last ? '0 : chk_q + BW'(1);
				end
				OP_LATCH: begin
					fidx_q    <= '0;
					found_q   <= 1'b0;
					slot_ok_q <= 1'b0;
				end
				OP_FT_SCAN: begin
					if (ft_hit) begin
						found_q <= 1'b1;
					end
					if (!ft_valid_q[fidx_q]) begin
						slot_ok_q <= 1'b1;
					end
					if (!ft_last) begin
						fidx_q <= fidx_q + FIW'(1);
					end
				end
				OP_ALLOC_INIT: begin
					chk_q       <= '0;
					taken_q     <= '0;
					have_prev_q <= 1'b0;
				end
				OP_ALLOC_SCAN: begin
					if (take) begin
						taken_q     <= taken_q + FW'(1);
						have_prev_q <= 1'b1;
					end
					if (!chk_last) begin
						chk_q <= chk_q + BW'(1);
					end
				end
				OP_ALLOC_TAIL: begin
					free_q             <= free_q - taken_q;
					ft_valid_q[slot_q] <= 1'b1;
				end
				OP_DEL_INIT: begin
					steps_q <= '0;
				end
				OP_DEL_WALK: begin
					if (rdata_q.used && (free_q != FW'(NUM_BLOCKS))) begin
						free_q <= free_q + FW'(1);
					end
					if (more_links) begin
						steps_q <= steps_q + BW'(1);
					end
				end
				OP_DEL_TAIL: begin
					ft_valid_q[pos_q] <= 1'b0;
				end
				OP_NOP, OP_REJECT, OP_REPLY: begin
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LATCH: begin
				kind_q  <= kind;
				key_q   <= file_key;
				count_q <= block_count;
			end
			OP_FT_SCAN: begin
				// first matching entry and lowest free entry win
				if (ft_hit && !found_q) begin
					pos_q    <= fidx_q;
					fstart_q <= ft_start_q[fidx_q];
				end
				if (!ft_valid_q[fidx_q] && !slot_ok_q) begin
					slot_q <= fidx_q;
				end
			end
			OP_REJECT: begin
				priority if (kind_q) begin
					status_q <= ST_NOT_FOUND;
				end else if (too_big) begin
					status_q <= ST_TOO_BIG;
				end else if (found_q) begin
					status_q <= ST_DUPLICATE;
				end else begin
					status_q <= ST_NO_ROOM;
				end
				start_q <= '0;
			end
			OP_ALLOC_SCAN: begin
				if (take) begin
					prev_q <= chk_q;
					if (!have_prev_q) begin
						first_q <= chk_q;
					end
				end
			end
			OP_ALLOC_TAIL: begin
				ft_key_q[slot_q]   <= key_q;
				ft_start_q[slot_q] <= first_q;
				status_q           <= ST_INSERTED;
				start_q            <= first_ext[4:0];
			end
			OP_DEL_INIT: begin
				cur_q <= fstart_q;
			end
			OP_DEL_WALK: begin
				if (more_links) begin
					cur_q <= rdata_q.link;
				end
			end
			OP_DEL_TAIL: begin
				status_q <= ST_DELETED;
				start_q  <= fstart_ext[4:0];
			end
			OP_NOP, OP_CLEAR, OP_ALLOC_INIT, OP_REPLY: begin
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/linked_block_allocator.sv */
// ----------------------------------------------------------------------------
// linked_block_allocator
// linked allocation of disk blocks with a small file table
// ----------------------------------------------------------------------------
// A transaction is taken when start is high while busy is low. Its single
// result appears on status, start_block and free_count for one cycle with
// done high; the receiver cannot stall, so it must take the result in that
// cycle. After reset the block memory is cleared one entry a cycle, so busy
// stays high until every entry is cleared. An insert scans the file table,
// then, unless it is rejected, sweeps the block memory from block 0 until it
// has taken the blocks it asked for or reached the last block, and links them
// into a chain. A delete scans the file table, then, if the key is found,
// walks the chain and frees its blocks. The file table is scanned one entry
// a cycle, and the block memory, which has one read and one write port, is
// swept or walked one block a cycle. A new start is taken in the same cycle
// that done is shown.
// ----------------------------------------------------------------------------
`include "linked_block_allocator_defines.svh"

module linked_block_allocator
	import lba_pkg::*;
#(
	parameter int NUM_BLOCKS = 32,
	parameter int NUM_FILES  = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       kind,
	input  logic [7:0] file_key,
	input  logic [5:0] block_count,
	output logic       done,
	output logic [2:0] status,
	output logic [4:0] start_block,
	output logic [5:0] free_count
);

	ctl_t    ctl;
	flags_t  flags;
	result_t dp_result;

	logic       done_q;
	logic [2:0] status_q;
	logic [4:0] start_q;
	logic [5:0] free_q;

	// microcode step counter and rom
	lba_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctl    (ctl)
	);

	// block memory, file table and counters
	lba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.NUM_FILES  (NUM_FILES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (ctl.op),
		.kind        (kind),
		.file_key    (file_key),
		.block_count (block_count),
		.flags       (flags),
		.result      (dp_result)
	);

	// only the idle step takes a transaction
	assign busy = !ctl.idle;

	// result strobe, one cycle per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctl.op == OP_REPLY);
		end
	end

	// result payload, held until the next reply
	always_ff @(posedge clk) begin
		if (ctl.op == OP_REPLY) begin
			status_q <= dp_result.status;
			start_q  <= dp_result.start_block;
			free_q   <= dp_result.free_count;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign start_block = start_q;
	assign free_count  = free_q;

	// a result always lands back in the idle step
	`LBA_ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, !busy, "result shown while busy")
	// an accepted transaction leaves the idle step
	`LBA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not start work")
	// reply strobe is a single cycle
	`LBA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "done held past one cycle")
	// status is a defined code
	`LBA_ASSERT_IMPL(a_status_code, clk, arst_n, done_q, status_q <= ST_NOT_FOUND, "bad status code")

endmodule
